// ===== src/afc_pkg.sv =====
// Shared types, widths and codes for the box/frustum classifier.
// Used by the channel interfaces and by every afc_* module.
package afc_pkg;

  localparam int CoordW     = 16;
  localparam int CoefW      = 16;
  localparam int NumPlanes  = 6;
  localparam int NumCorners = 8;
  localparam int CfgIdxW    = $clog2(NumPlanes);
  localparam int CfgDataW   = 4 * CoefW;
  localparam int ProdW      = CoordW + CoefW;   // coef * coord
  localparam int PsumW      = ProdW + 1;        // two terms
  localparam int SumW       = PsumW + 1;        // four terms
  localparam int OffShift   = 14;               // Q12.4 offset up to Q.18
  localparam int CountW     = $clog2(NumCorners + 1);
  localparam int VisW       = 2;

  // Result classes
  typedef enum logic [VisW-1:0] {
    VisOutside = 2'd0,
    VisPartial = 2'd1,
    VisInside  = 2'd2
  } vis_e;

  // One plane register: a in the low quarter, d in the top quarter
  typedef struct packed {
    logic [CoefW-1:0] d;
    logic [CoefW-1:0] c;
    logic [CoefW-1:0] b;
    logic [CoefW-1:0] a;
  } plane_t;

  // Registered box corners
  typedef struct packed {
    logic [CoordW-1:0] min_x;
    logic [CoordW-1:0] min_y;
    logic [CoordW-1:0] min_z;
    logic [CoordW-1:0] max_x;
    logic [CoordW-1:0] max_y;
    logic [CoordW-1:0] max_z;
  } box_t;

  typedef logic [ProdW-1:0] prod_t;
  typedef logic [PsumW-1:0] psum_t;
  typedef logic [SumW-1:0]  sum_t;

  // Per-plane products of each normal component with both box bounds
  typedef struct packed {
    prod_t ax_lo;
    prod_t ax_hi;
    prod_t by_lo;
    prod_t by_hi;
    prod_t cz_lo;
    prod_t cz_hi;
  } plane_prod_t;

  // Per-plane partial sums: xy indexed by {x_hi, y_hi}, zd by z_hi
  typedef struct packed {
    psum_t [3:0] xy;
    psum_t [1:0] zd;
  } plane_psum_t;

  // Signed 16 x 16 product, exact in 32 bits
  function automatic prod_t coef_mul(logic [CoefW-1:0] coef, logic [CoordW-1:0] coord);
    logic signed [ProdW-1:0] cw;
    logic signed [ProdW-1:0] xw;
    cw = ProdW'($signed(coef));
    xw = ProdW'($signed(coord));
    return prod_t'(cw * xw);
  endfunction

endpackage

// ===== src/afc_intf.sv =====
// Valid/ready channel interfaces for boxes, results and plane writes.
// Depends on afc_pkg for field widths.
interface afc_box_if;
  logic                           valid;
  logic                           ready;
  logic signed [afc_pkg::CoordW-1:0] box_min_x;
  logic signed [afc_pkg::CoordW-1:0] box_min_y;
  logic signed [afc_pkg::CoordW-1:0] box_min_z;
  logic signed [afc_pkg::CoordW-1:0] box_max_x;
  logic signed [afc_pkg::CoordW-1:0] box_max_y;
  logic signed [afc_pkg::CoordW-1:0] box_max_z;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, output ready);
endinterface

interface afc_result_if;
  logic                          valid;
  logic                          ready;
  logic [afc_pkg::VisW-1:0]      visibility;
  logic [afc_pkg::CountW-1:0]    inside_corners;

  modport source (output valid, visibility, inside_corners, input ready);
  modport sink   (input valid, visibility, inside_corners, output ready);
endinterface

interface afc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [afc_pkg::CfgIdxW-1:0]    index;
  logic [afc_pkg::CfgDataW-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== src/afc_cfg_regs.sv =====
// Six frustum plane registers written through the configuration channel.
// Depends on afc_pkg and afc_cfg_if.
module afc_cfg_regs (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  afc_cfg_if.sink                                    cfg_i,
  output afc_pkg::plane_t [afc_pkg::NumPlanes-1:0]   planes_o
);

  afc_pkg::plane_t [afc_pkg::NumPlanes-1:0] planes_q;
  logic                                     wr_en;

  // Always take a write; indexes past the last plane are dropped
  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      planes_q <= '0;
    end else if (wr_en && (32'(cfg_i.index) < afc_pkg::NumPlanes)) begin
      planes_q[cfg_i.index] <= afc_pkg::plane_t'(cfg_i.wdata);
    end
  end

  assign planes_o = planes_q;

  // Out-of-range write leaves every plane untouched
  a_bad_idx_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (32'(cfg_i.index) >= afc_pkg::NumPlanes)) |=> $stable(planes_q))
    else $error("plane registers changed on out-of-range write");

  // In-range write lands in the addressed plane
  a_write_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && (32'(cfg_i.index) < afc_pkg::NumPlanes))
    |=> (planes_q[$past(cfg_i.index)] == afc_pkg::plane_t'($past(cfg_i.wdata))))
    else $error("plane write did not land");

endmodule

// ===== src/afc_mul.sv =====
// Box capture stage and plane-by-coordinate product stage.
// Depends on afc_pkg and afc_box_if.
module afc_mul (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  afc_box_if.sink                                       box_i,
  input  afc_pkg::plane_t [afc_pkg::NumPlanes-1:0]      planes_i,
  output logic                                          prod_valid_o,
  input  logic                                          prod_ready_i,
  output afc_pkg::plane_prod_t [afc_pkg::NumPlanes-1:0] prod_o
);

  afc_pkg::box_t                               box_q;
  logic                                        box_valid_q;
  logic                                        prod_adv;
  afc_pkg::plane_prod_t [afc_pkg::NumPlanes-1:0] prod_d;
  afc_pkg::plane_prod_t [afc_pkg::NumPlanes-1:0] prod_q;
  logic                                        prod_valid_q;

  // Each stage advances when it is empty or its contents move on
  assign prod_adv    = !prod_valid_q || prod_ready_i;
  assign box_i.ready = !box_valid_q || prod_adv;

  // Capture the box request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
    end else if (box_i.ready) begin
      box_valid_q <= box_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_i.valid && box_i.ready) begin
      box_q.min_x <= box_i.box_min_x;
      box_q.min_y <= box_i.box_min_y;
      box_q.min_z <= box_i.box_min_z;
      box_q.max_x <= box_i.box_max_x;
      box_q.max_y <= box_i.box_max_y;
      box_q.max_z <= box_i.box_max_z;
    end
  end

  // Six products per plane, one multiplier each
  always_comb begin
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      prod_d[p].ax_lo = afc_pkg::coef_mul(planes_i[p].a, box_q.min_x);
      prod_d[p].ax_hi = afc_pkg::coef_mul(planes_i[p].a, box_q.max_x);
      prod_d[p].by_lo = afc_pkg::coef_mul(planes_i[p].b, box_q.min_y);
      prod_d[p].by_hi = afc_pkg::coef_mul(planes_i[p].b, box_q.max_y);
      prod_d[p].cz_lo = afc_pkg::coef_mul(planes_i[p].c, box_q.min_z);
      prod_d[p].cz_hi = afc_pkg::coef_mul(planes_i[p].c, box_q.max_z);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (prod_adv) begin
      prod_valid_q <= box_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (box_valid_q && prod_adv) begin
      prod_q <= prod_d;
    end
  end

  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

endmodule

// ===== src/afc_sum.sv =====
// Partial-sum stage and per-corner plane sign stage.
// Depends on afc_pkg; fed by afc_mul, feeds afc_classify.
module afc_sum (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           prod_valid_i,
  output logic                                           prod_ready_o,
  input  afc_pkg::plane_prod_t [afc_pkg::NumPlanes-1:0]  prod_i,
  input  afc_pkg::plane_t [afc_pkg::NumPlanes-1:0]       planes_i,
  output logic                                           pos_valid_o,
  input  logic                                           pos_ready_i,
  output logic [afc_pkg::NumCorners-1:0][afc_pkg::NumPlanes-1:0] pos_o
);

  afc_pkg::plane_psum_t [afc_pkg::NumPlanes-1:0] psum_d;
  afc_pkg::plane_psum_t [afc_pkg::NumPlanes-1:0] psum_q;
  logic                                          psum_valid_q;
  logic                                          pos_adv;
  logic [afc_pkg::NumCorners-1:0][afc_pkg::NumPlanes-1:0] pos_d;
  logic [afc_pkg::NumCorners-1:0][afc_pkg::NumPlanes-1:0] pos_q;
  logic                                          pos_valid_q;

  assign pos_adv      = !pos_valid_q || pos_ready_i;
  assign prod_ready_o = !psum_valid_q || pos_adv;

  // Pair x with y for each bound mix, and z with the scaled offset
  always_comb begin
    afc_pkg::prod_t                 px;
    afc_pkg::prod_t                 py;
    afc_pkg::prod_t                 pz;
    logic [afc_pkg::CoefW-1:0]      dv;
    afc_pkg::psum_t                 dsh;
    for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
      for (int j = 0; j < 4; j++) begin
        px = (j >= 2)      ? prod_i[p].ax_hi : prod_i[p].ax_lo;
        py = ((j % 2) == 1) ? prod_i[p].by_hi : prod_i[p].by_lo;
        psum_d[p].xy[j] = {px[afc_pkg::ProdW-1], px} + {py[afc_pkg::ProdW-1], py};
      end
      dv  = planes_i[p].d;
      dsh = {{(afc_pkg::PsumW - afc_pkg::CoefW - afc_pkg::OffShift){dv[afc_pkg::CoefW-1]}},
             dv, {afc_pkg::OffShift{1'b0}}};
      for (int j = 0; j < 2; j++) begin
        pz = (j == 1) ? prod_i[p].cz_hi : prod_i[p].cz_lo;
        psum_d[p].zd[j] = {pz[afc_pkg::ProdW-1], pz} + dsh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_valid_q <= 1'b0;
    end else if (prod_ready_o) begin
      psum_valid_q <= prod_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_valid_i && prod_ready_o) begin
      psum_q <= psum_d;
    end
  end

  // Finish each corner's plane sum and keep only "strictly positive"
  always_comb begin
    afc_pkg::psum_t xy;
    afc_pkg::psum_t zd;
    afc_pkg::sum_t  s;
    for (int k = 0; k < afc_pkg::NumCorners; k++) begin
      for (int p = 0; p < afc_pkg::NumPlanes; p++) begin
        xy = psum_q[p].xy[2'(k >> 1)];
        zd = psum_q[p].zd[1'(k & 1)];
        s  = {xy[afc_pkg::PsumW-1], xy} + {zd[afc_pkg::PsumW-1], zd};
        pos_d[k][p] = !s[afc_pkg::SumW-1] && (s != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_valid_q <= 1'b0;
    end else if (pos_adv) begin
      pos_valid_q <= psum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (psum_valid_q && pos_adv) begin
      pos_q <= pos_d;
    end
  end

  assign pos_valid_o = pos_valid_q;
  assign pos_o       = pos_q;

endmodule

// ===== src/afc_classify.sv =====
// Corner count, visibility class and the output register.
// Depends on afc_pkg and afc_result_if; fed by afc_sum.
module afc_classify (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  logic                                                   pos_valid_i,
  output logic                                                   pos_ready_o,
  input  logic [afc_pkg::NumCorners-1:0][afc_pkg::NumPlanes-1:0] pos_i,
  afc_result_if.source                                           result_o
);

  logic [afc_pkg::CountW-1:0] count_d;
  afc_pkg::vis_e              vis_d;
  logic [afc_pkg::CountW-1:0] count_q;
  afc_pkg::vis_e              vis_q;
  logic                       res_valid_q;

  assign pos_ready_o = !res_valid_q || result_o.ready;

  // Count corners inside all planes, then class the box
  always_comb begin
    count_d = '0;
    for (int k = 0; k < afc_pkg::NumCorners; k++) begin
      count_d = count_d + afc_pkg::CountW'(&pos_i[k]);
    end
    if (count_d == afc_pkg::CountW'(afc_pkg::NumCorners)) begin
      vis_d = afc_pkg::VisInside;
    end else if (count_d == '0) begin
      vis_d = afc_pkg::VisOutside;
    end else begin
      vis_d = afc_pkg::VisPartial;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (pos_ready_o) begin
      res_valid_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_valid_i && pos_ready_o) begin
      count_q <= count_d;
      vis_q   <= vis_d;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.visibility     = vis_q;
  assign result_o.inside_corners = count_q;

  // Inside exactly when every corner counts
  a_inside_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((vis_q == afc_pkg::VisInside) ==
                     (count_q == afc_pkg::CountW'(afc_pkg::NumCorners))))
    else $error("inside class does not match corner count");

  // Outside exactly when no corner counts
  a_outside_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ((vis_q == afc_pkg::VisOutside) == (count_q == '0)))
    else $error("outside class does not match corner count");

  // A request taken from the sign stage shows up as a result next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_valid_i && pos_ready_o) |=> res_valid_q)
    else $error("accepted request lost at output register");

endmodule

// ===== src/aabb_frustum_classifier_unit.sv =====
// Axis-aligned box versus view frustum classifier, top level.
// Depends on afc_pkg, the afc_* interfaces and modules afc_cfg_regs,
// afc_mul, afc_sum and afc_classify.
//
// Usage:
//   cfg_i    : plane writes, index 0..5 = near, far, left, right, top,
//              bottom; each 64-bit word packs a, b, c (Q1.14) and d (Q12.4)
//              from the low end up. Indexes 6 and 7 are dropped. Always ready.
//              Write planes only while no box request is in flight.
//   box_i    : one box request (min/max corners, Q12.4) per accepted beat.
//   result_o : visibility (outside, partial, inside) and the count of
//              corners strictly positive against all six planes.
// Pipeline: the box moves through the capture, products, partial sums, plane
//   signs and output registers in that order before the result is valid.
// Throughput: one box per clock while result_o.ready stays high; each stage
//   holds its own multipliers and adders, so boxes overlap in the five stages.
// Reset: all planes clear to zero (every box then reads outside) and all
//   stage valid bits clear. When result_o.ready is low the pipeline fills
//   its empty stages, then holds; box_i.ready drops once all are full.
module aabb_frustum_classifier_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  afc_cfg_if.sink      cfg_i,
  afc_box_if.sink      box_i,
  afc_result_if.source result_o
);

  afc_pkg::plane_t [afc_pkg::NumPlanes-1:0]      planes;
  logic                                          prod_valid;
  logic                                          prod_ready;
  afc_pkg::plane_prod_t [afc_pkg::NumPlanes-1:0] prod;
  logic                                          pos_valid;
  logic                                          pos_ready;
  logic [afc_pkg::NumCorners-1:0][afc_pkg::NumPlanes-1:0] pos;

  // Plane registers
  afc_cfg_regs u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .planes_o (planes)
  );

  // Capture and products
  afc_mul u_mul (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .box_i        (box_i),
    .planes_i     (planes),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  // Sums and signs
  afc_sum u_sum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .planes_i     (planes),
    .pos_valid_o  (pos_valid),
    .pos_ready_i  (pos_ready),
    .pos_o        (pos)
  );

  // Count, class and output
  afc_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pos_valid_i (pos_valid),
    .pos_ready_o (pos_ready),
    .pos_i       (pos),
    .result_o    (result_o)
  );

endmodule
